// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, sampled on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds in the same cycle as cond.
`define SIORD_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that expr holds in the cycle after cond.
`define SIORD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/siord_pkg.sv =====
`default_nettype none

package siord_pkg;

    localparam int MAX_BUTTONS  = 24;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_ENCODERS = 8;
    localparam int NUM_BANKS    = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] CHAR_OFFSET = 8'h21;
    localparam logic [7:0] START_CHAR  = 8'h70;
    localparam logic [7:0] END_CHAR    = 8'h0a;

    localparam logic [1:0] REG_BUTTONS  = 2'd0;
    localparam logic [1:0] REG_CHANNELS = 2'd1;
    localparam logic [1:0] REG_ENCODERS = 2'd2;

    typedef enum logic [1:0] {
        KIND_BUTTON  = 2'd0,
        KIND_ANALOG  = 2'd1,
        KIND_ENCODER = 2'd2,
        KIND_FRAME   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [4:0] buttons;
        logic [3:0] channels;
        logic [3:0] encoders;
    } cfg_t;

    typedef struct packed {
        logic       bank;
        logic [5:0] end_pos;
    } job_t;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [5:0] pos;
        logic [7:0] data;
    } wr_t;

    // two characters for each started bank of eight buttons
    function automatic logic [2:0] button_chars(input logic [4:0] buttons);
        logic [5:0] sum;
        sum = {1'b0, buttons} + 6'd7;
        return {sum[4:3], 1'b0};
    endfunction

    function automatic logic [5:0] report_len(input cfg_t c);
        return 6'd2 + {1'b0, c.channels, 1'b0} + {c.encoders, 2'b00}
            + {3'b000, button_chars(c.buttons)};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/siord_front.sv =====
`default_nettype none

module siord_front
    import siord_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire cfg_t       cfg,
    input  wire logic       q_full,
    output logic            push,
    output job_t            push_job,
    output wr_t             wr
);

`include "assert_macros.svh"

    logic       reading_reg, reading_next;
    logic [5:0] count_reg, count_next;
    logic       bank_reg, bank_next;
    logic [5:0] count_inc;
    logic [5:0] len;
    logic       take;

    assign len       = report_len(cfg);
    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;
    assign count_inc = count_reg + 6'd1;

    always_comb
    begin
        reading_next     = reading_reg;
        count_next       = count_reg;
        bank_next        = bank_reg;
        push             = 1'b0;
        push_job.bank    = bank_reg;
        push_job.end_pos = len - 6'd1;
        wr.en            = 1'b0;
        wr.bank          = bank_reg;
        wr.pos           = count_reg;
        wr.data          = rx_byte;
        if (take)
        begin
            if (!reading_reg)
            begin
                if (rx_byte == START_CHAR)
                begin
                    wr.en        = 1'b1;
                    wr.pos       = 6'd0;
                    reading_next = 1'b1;
                    count_next   = 6'd1;
                end
            end
            else
            begin
                wr.en = 1'b1;
                if (count_inc >= len)
                begin
                    reading_next = 1'b0;
                    count_next   = 6'd0;
                    push         = 1'b1;
                    bank_next    = ~bank_reg;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_reg <= 1'b0;
            count_reg   <= 6'd0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            reading_reg <= reading_next;
            count_reg   <= count_next;
            bank_reg    <= bank_next;
        end
    end

    `SIORD_ASSERT_NEXT(a_push_resyncs, push, !reading_reg && count_reg == 6'd0, "no resync")

endmodule

`default_nettype wire

// ===== rtl/siord_queue.sv =====
`default_nettype none

module siord_queue
    import siord_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      full,
    output logic      empty
);

`include "assert_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head  = entry_reg[rptr_reg];
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `SIORD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overrun")

endmodule

`default_nettype wire

// ===== rtl/siord_back.sv =====
`default_nettype none

module siord_back
    import siord_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire wr_t                wr,
    input  wire logic               q_empty,
    input  wire job_t               head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              kind,
    output logic [2:0]              item_index,
    output logic [3:0]              button_bits,
    output logic [11:0]             analog_code,
    output logic signed [23:0]      encoder_ticks,
    output logic                    last_of_report
);

`include "assert_macros.svh"

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_READ,
        B_ACC,
        B_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_BTN,
        PH_ANA,
        PH_ENC
    } phase_t;

    logic [7:0] mem [NUM_BANKS][BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    state_t     state_reg;
    phase_t     phase_reg;
    logic [2:0] item_reg;
    logic [1:0] k_reg;
    logic [5:0] pos_reg;
    logic [4:0] rem_reg;
    logic [23:0] acc_reg;
    kind_t      kind_reg;
    logic [2:0] index_reg;
    logic [3:0] bits_reg;
    logic [11:0] code_reg;
    logic [23:0] ticks_reg;
    logic       last_reg;

    logic [5:0] rd_pos;
    logic [7:0] chr;
    logic [5:0] six;
    logic [2:0] nb;
    logic [4:0] total;
    logic [1:0] k_last;
    logic       end_ok;

    assign nb     = button_chars(cfg.buttons);
    assign total  = {2'b00, nb} + {1'b0, cfg.channels} + {1'b0, cfg.encoders};
    assign chr    = rd_data_reg - CHAR_OFFSET;
    assign six    = chr[5:0];
    assign end_ok = (rd_data_reg == END_CHAR);
    assign rd_pos = (state_reg == B_IDLE) ? head.end_pos : pos_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_BTN:  k_last = 2'd0;
            PH_ANA:  k_last = 2'd1;
            PH_ENC:  k_last = 2'd3;
            default: k_last = 2'd0;
        endcase
    end

    assign out_valid = (state_reg == B_OUT);
    assign pop = (out_valid && out_ready && rem_reg == 5'd1)
        || (state_reg == B_CHECK && end_ok && total == 5'd0);

    assign kind           = kind_reg;
    assign item_index     = index_reg;
    assign button_bits    = bits_reg;
    assign analog_code    = code_reg;
    assign encoder_ticks  = signed'(ticks_reg);
    assign last_of_report = last_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bank][wr.pos[ADDR_W-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[head.bank][rd_pos[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            phase_reg <= PH_BTN;
            item_reg  <= 3'd0;
            k_reg     <= 2'd0;
            pos_reg   <= 6'd0;
            rem_reg   <= 5'd0;
            acc_reg   <= 24'd0;
            kind_reg  <= KIND_BUTTON;
            index_reg <= 3'd0;
            bits_reg  <= 4'd0;
            code_reg  <= 12'd0;
            ticks_reg <= 24'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= B_CHECK;
                    end
                end
                B_CHECK:
                begin
                    if (!end_ok)
                    begin
                        kind_reg  <= KIND_FRAME;
                        index_reg <= 3'd0;
                        bits_reg  <= 4'd0;
                        code_reg  <= 12'd0;
                        ticks_reg <= 24'd0;
                        last_reg  <= 1'b1;
                        rem_reg   <= 5'd1;
                        state_reg <= B_OUT;
                    end
                    else if (total == 5'd0)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= total;
                        pos_reg   <= 6'd1;
                        state_reg <= B_READ;
                        if (nb != 3'd0)
                        begin
                            phase_reg <= PH_BTN;
                            item_reg  <= nb - 3'd1;
                        end
                        else if (cfg.channels != 4'd0)
                        begin
                            phase_reg <= PH_ANA;
                            item_reg  <= 3'd0;
                        end
                        else
                        begin
                            phase_reg <= PH_ENC;
                            item_reg  <= 3'd0;
                        end
                    end
                end
                B_READ:
                begin
                    pos_reg   <= pos_reg + 6'd1;
                    k_reg     <= 2'd0;
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    if (phase_reg == PH_ENC)
                    begin
                        acc_reg <= {six, acc_reg[23:6]};
                    end
                    else
                    begin
                        acc_reg <= {acc_reg[17:0], six};
                    end
                    if (k_reg == k_last)
                    begin
                        index_reg <= item_reg;
                        last_reg  <= (rem_reg == 5'd1);
                        bits_reg  <= 4'd0;
                        code_reg  <= 12'd0;
                        ticks_reg <= 24'd0;
                        unique case (phase_reg)
                            PH_BTN:
                            begin
                                kind_reg <= KIND_BUTTON;
                                bits_reg <= chr[3:0];
                            end
                            PH_ANA:
                            begin
                                kind_reg <= KIND_ANALOG;
                                code_reg <= {acc_reg[5:0], six};
                            end
                            default:
                            begin
                                kind_reg  <= KIND_ENCODER;
                                ticks_reg <= {six, acc_reg[23:6]};
                            end
                        endcase
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        k_reg   <= k_reg + 2'd1;
                        pos_reg <= pos_reg + 6'd1;
                    end
                end
                B_OUT:
                begin
                    if (out_ready)
                    begin
                        rem_reg <= rem_reg - 5'd1;
                        if (rem_reg == 5'd1)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            state_reg <= B_READ;
                            unique case (phase_reg)
                                PH_BTN:
                                begin
                                    if (item_reg == 3'd0)
                                    begin
                                        phase_reg <= (cfg.channels != 4'd0) ? PH_ANA : PH_ENC;
                                    end
                                    else
                                    begin
                                        item_reg <= item_reg - 3'd1;
                                    end
                                end
                                PH_ANA:
                                begin
                                    if ({1'b0, item_reg} == cfg.channels - 4'd1)
                                    begin
                                        phase_reg <= PH_ENC;
                                        item_reg  <= 3'd0;
                                    end
                                    else
                                    begin
                                        item_reg <= item_reg + 3'd1;
                                    end
                                end
                                default:
                                begin
                                    item_reg <= item_reg + 3'd1;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `SIORD_ASSERT_IMPL(a_pop_has_job, pop, !q_empty, "pop from empty queue")
    `SIORD_ASSERT_IMPL(a_frame_last, out_valid && kind_reg == KIND_FRAME, last_reg, "frame error not last")

endmodule

`default_nettype wire

// ===== rtl/serial_io_report_decoder.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    rx_byte
// output    out_valid/out_ready  kind, item_index, button_bits, analog_code,
//                                encoder_ticks, last_of_report
// config    APB write/read       button_count, channel_count, encoder_count
//
// The front takes one byte per cycle and stalls only while both buffer banks hold reports.
// A completed report passes idle and check states for the newline check; each result then
// takes a read, accumulation of its 1, 2 or 4 characters, and output until out_ready.
// The back-end is bound by the single read port of the report buffer.
// rst_n clears all control state asynchronously; buffer contents are not cleared.
`default_nettype none

module serial_io_report_decoder
    import siord_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic [1:0]              kind,
    output logic [2:0]              item_index,
    output logic [3:0]              button_bits,
    output logic [11:0]             analog_code,
    output logic signed [23:0]      encoder_ticks,
    output logic                    last_of_report,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic [4:0] btn_wr;
    logic [3:0] ch_wr;
    logic [3:0] enc_wr;

    logic push;
    job_t push_job;
    wr_t  wr;
    logic pop;
    job_t head;
    logic q_full;
    logic q_empty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign btn_wr = (pwdata[4:0] > 5'(MAX_BUTTONS)) ? 5'(MAX_BUTTONS) : pwdata[4:0];
    assign ch_wr  = (pwdata[3:0] > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : pwdata[3:0];
    assign enc_wr = (pwdata[3:0] > 4'(MAX_ENCODERS)) ? 4'(MAX_ENCODERS) : pwdata[3:0];

    always_comb
    begin
        unique case (reg_idx)
            REG_BUTTONS:  prdata = {27'd0, cfg_reg.buttons};
            REG_CHANNELS: prdata = {28'd0, cfg_reg.channels};
            REG_ENCODERS: prdata = {28'd0, cfg_reg.encoders};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BUTTONS:  cfg_reg.buttons  <= btn_wr;
                REG_CHANNELS: cfg_reg.channels <= ch_wr;
                REG_ENCODERS: cfg_reg.encoders <= enc_wr;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    siord_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job),
        .wr       (wr)
    );

    siord_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    siord_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .wr             (wr),
        .q_empty        (q_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .item_index     (item_index),
        .button_bits    (button_bits),
        .analog_code    (analog_code),
        .encoder_ticks  (encoder_ticks),
        .last_of_report (last_of_report)
    );

endmodule

`default_nettype wire
